@@ design/ssac_pkg.sv @@
// ----------------------------------------------------------------------------
// ssac_pkg
// Shared types and codes for the sorted site agreement counter.
// ----------------------------------------------------------------------------
package ssac_pkg;

	localparam int POS_W    = 30;
	localparam int ALLELE_W = 8;
	localparam int COUNT_W  = 7;

	// Item modes
	localparam logic [1:0] MODE_LOAD_A  = 2'd0;
	localparam logic [1:0] MODE_LOAD_B  = 2'd1;
	localparam logic [1:0] MODE_COMPARE = 2'd2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [1:0]          mode;
		logic [POS_W-1:0]    position;
		logic [ALLELE_W-1:0] allele;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] agree_count;
		logic [COUNT_W-1:0] disagree_count;
		logic               overflow;
	} out_item_t;

	// One stored list entry
	typedef struct packed {
		logic [POS_W-1:0]    position;
		logic [ALLELE_W-1:0] allele;
	} site_t;

	localparam int SITE_W = $bits(site_t);

endpackage

@@ design/sorted_site_agreement_count_top.sv @@
// ----------------------------------------------------------------------------
// sorted_site_agreement_count_top
// Loads two ascending site lists and merge-walks them to count shared sites.
// ----------------------------------------------------------------------------
// Walk: a compare item runs S walk steps, S at most a_len + b_len - 1
//   (zero when a list is empty); input is held off until the result is out.
// Throughput: the walk does one step per cycle, set by the single read port of
//   each list RAM; the result then lands in the output register.
// Reset: arst_n clears both list lengths, the lost-load flag, the sequencer
//   and the output valid flag. RAM contents are not cleared.
module sorted_site_agreement_count_top #(
	parameter int MAX_SITES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ssac_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ssac_pkg::out_item_t out_data
);

	import ssac_pkg::*;

	localparam int LW = $clog2(MAX_SITES + 1);  // length / pointer width
	localparam int IW = $clog2(MAX_SITES);      // RAM index width
	localparam logic [LW-1:0] FULL = LW'(MAX_SITES);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t             state_q;
	logic [LW-1:0]      a_len_q, b_len_q;
	logic               lost_q;
	logic [LW-1:0]      ia_q, jb_q;
	logic [LW-1:0]      ia_nx, jb_nx;
	logic [COUNT_W-1:0] agree_q, disagree_q;
	logic               out_valid_q;
	out_item_t          out_data_q;

	logic               in_fire;
	logic               slot_free;
	logic               hit, walk_end;
	logic               wr_a, wr_b;
	logic [SITE_W-1:0]  a_rdata, b_rdata;
	site_t              a_rd, b_rd, wr_site;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	// Loads only happen in idle and the walk only reads, so the write port is
	// never used while the walk reads the lists.
	assign wr_site.position = in_data.position;
	assign wr_site.allele   = in_data.allele;
	assign wr_a = in_fire && (in_data.mode == MODE_LOAD_A) && (a_len_q != FULL);
	assign wr_b = in_fire && (in_data.mode == MODE_LOAD_B) && (b_len_q != FULL);

	ssac_ram #(.WIDTH(SITE_W), .DEPTH(MAX_SITES)) u_ram_a (
		.clk     (clk),
		.wr_en   (wr_a),
		.wr_addr (a_len_q[IW-1:0]),
		.wr_data (wr_site),
		.rd_addr (ia_nx[IW-1:0]),
		.rd_data (a_rdata)
	);

	ssac_ram #(.WIDTH(SITE_W), .DEPTH(MAX_SITES)) u_ram_b (
		.clk     (clk),
		.wr_en   (wr_b),
		.wr_addr (b_len_q[IW-1:0]),
		.wr_data (wr_site),
		.rd_addr (jb_nx[IW-1:0]),
		.rd_data (b_rdata)
	);

	assign a_rd = site_t'(a_rdata);
	assign b_rd = site_t'(b_rdata);

	// Walk step: the RAM outputs hold A[ia] and B[jb]. Advance B while the A
	// position is greater; otherwise score an equal position and advance A.
	// The next pointers also address the RAMs, so the next pair arrives in
	// the following cycle. In idle the pointers aim at entry zero so a compare
	// finds the first pair ready when the walk starts.
	always_comb begin
		ia_nx    = ia_q;
		jb_nx    = jb_q;
		hit      = 1'b0;
		walk_end = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ia_nx = '0;
				jb_nx = '0;
			end
			ST_WALK: begin
				if (a_rd.position > b_rd.position) begin
					jb_nx = jb_q + 1'b1;
				end else begin
					ia_nx = ia_q + 1'b1;
				end
				hit      = (a_rd.position == b_rd.position);
				walk_end = (ia_nx == a_len_q) || (jb_nx == b_len_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			a_len_q    <= '0;
			b_len_q    <= '0;
			lost_q     <= 1'b0;
			ia_q       <= '0;
			jb_q       <= '0;
			agree_q    <= '0;
			disagree_q <= '0;
		end else begin
			ia_q <= ia_nx;
			jb_q <= jb_nx;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (in_data.mode)
							MODE_LOAD_A: begin
								// drop and flag a load into a full list
								if (a_len_q != FULL) begin
									a_len_q <= a_len_q + 1'b1;
								end else begin
									lost_q <= 1'b1;
								end
							end
							MODE_LOAD_B: begin
								if (b_len_q != FULL) begin
									b_len_q <= b_len_q + 1'b1;
								end else begin
									lost_q <= 1'b1;
								end
							end
							MODE_COMPARE: begin
								agree_q    <= '0;
								disagree_q <= '0;
								// an empty list has nothing to walk
								if ((a_len_q == '0) || (b_len_q == '0)) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_WALK;
								end
							end
							default: begin
								// unused mode: ignore
							end
						endcase
					end
				end
				ST_WALK: begin
					if (hit) begin
						if (a_rd.allele == b_rd.allele) begin
							if (agree_q != COUNT_MAX) begin
								agree_q <= agree_q + 1'b1;
							end
						end else begin
							if (disagree_q != COUNT_MAX) begin
								disagree_q <= disagree_q + 1'b1;
							end
						end
					end
					if (walk_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register can take the result
					if (slot_free) begin
						a_len_q <= '0;
						b_len_q <= '0;
						lost_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: parts the walk from the consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && slot_free) begin
			out_data_q.agree_count    <= agree_q;
			out_data_q.disagree_count <= disagree_q;
			out_data_q.overflow       <= lost_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ design/ssac_ram.sv @@
// ----------------------------------------------------------------------------
// ssac_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ssac_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ design/ssac_checker.sv @@
// ----------------------------------------------------------------------------
// ssac_checker
// Port-level assertions for the sorted site agreement counter.
// ----------------------------------------------------------------------------
module ssac_checker #(
	parameter int MAX_SITES = 64
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input ssac_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input ssac_pkg::out_item_t out_data
);

	import ssac_pkg::*;

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// A compare item blocks further input while the walk runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.mode == MODE_COMPARE) |=> !in_ready)
		else $error("input taken during a compare");

	// A new result only appears at the end of a compare, when input is held.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result without a compare");

	// Shared sites cannot exceed the list capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(out_data.agree_count) + 32'(out_data.disagree_count)
			<= 32'(MAX_SITES)))
		else $error("count total exceeds capacity");

endmodule

bind sorted_site_agreement_count_top ssac_checker #(.MAX_SITES(MAX_SITES)) u_ssac_checker (.*);
